[design/gfa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_pkg: shared types and constants for the Goldilocks field ALU
// Holds the field prime, operation codes and the controller/datapath command
// and status structures.
// ----------------------------------------------------------------------------
package gfa_pkg;

    localparam int unsigned OpW = 3;
    localparam int unsigned WordW = 64;
    localparam int unsigned ExpCntW = 7;
    localparam logic [WordW-1:0] FieldP = 64'hFFFF_FFFF_0000_0001;
    localparam logic [WordW-1:0] FoldEps = 64'h0000_0000_FFFF_FFFF;
    localparam logic [WordW-1:0] InvExp = 64'hFFFF_FFFE_FFFF_FFFF;

    typedef enum logic [OpW-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_NEG = 3'd3,
        OP_POW = 3'd4,
        OP_INV = 3'd5,
        OP_RS6 = 3'd6,
        OP_RS7 = 3'd7
    } t_op;

    // Multiplier operand selection.
    typedef enum logic [1:0] {
        MS_AB  = 2'd0,   // a * b
        MS_AP  = 2'd1,   // acc * base
        MS_SQ  = 2'd2    // base * base
    } t_msel;

    typedef struct packed {
        logic  load;      // capture request operands
        logic  simple;    // compute add/sub/neg/zero result, or 1 for power, into acc; load base and exponent
        logic  mul_go;    // launch one multiplication
        t_msel msel;
        logic  wr_acc;    // write finished product to acc
        logic  wr_base;   // write finished product to base
        logic  shift_e;   // shift exponent right by one
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic e_bit;
    } t_sts;

    function automatic logic [WordW-1:0] canon(input logic [WordW-1:0] x);
        return (x >= FieldP) ? (x - FieldP) : x;
    endfunction

endpackage
`default_nettype wire

[design/goldilocks_field_alu_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// goldilocks_field_alu_core: arithmetic unit over p = 2^64 - 2^32 + 1
// Add, subtract, multiply, negate, power and Fermat inverse, one canonical
// result and a zero flag per request item.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata bits (low first)            tuser
// s_axis    in         operand_a[63:0], operand_b[127:64]  req_type[2:0]
// m_axis    out        result_value[63:0]                  result_is_zero
//
// Add, subtract, negate and the unused codes do not use the multiplier;
// multiply uses it once. Power and inverse run 64 exponent bits on one
// shared multiplier (launch plus six phases per product), with a squaring
// for a clear bit and a multiply and a squaring for a set bit. Reset is
// synchronous and active low and clears only control state. A result waits
// in the output register until taken; the next item is accepted once the
// held result has gone.
// ----------------------------------------------------------------------------
module goldilocks_field_alu_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [127:0]  s_axis_tdata,   // operand_a, operand_b
    input  wire logic [2:0]    s_axis_tuser,   // req_type
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [63:0]        m_axis_tdata,   // result_value
    output logic               m_axis_tuser    // result_is_zero
);
    gfa_pkg::t_cmd s_cmd;
    gfa_pkg::t_sts s_sts;
    logic [gfa_pkg::OpW-1:0] s_op;

    // The sequencer decides; the datapath holds operands and the multiplier.
    gfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .o_op        (s_op),
        .o_cmd       (s_cmd),
        .i_sts       (s_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    gfa_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (s_cmd),
        .i_op     (s_op),
        .i_a      (s_axis_tdata[63:0]),
        .i_b      (s_axis_tdata[127:64]),
        .o_sts    (s_sts),
        .o_result (m_axis_tdata)
    );

    // The zero flag follows the held result directly.
    assign m_axis_tuser = (m_axis_tdata == '0);
endmodule
`default_nettype wire

[design/gfa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_datapath: operand registers, add/sub unit and multi-cycle multiplier
// The 64x64 product is built from four 32x32 partial products in phases
// 0 to 3, then summed in phase 4 and folded modulo p in phase 5.
// ----------------------------------------------------------------------------
module gfa_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire gfa_pkg::t_cmd              i_cmd,
    input  wire logic [gfa_pkg::OpW-1:0]    i_op,
    input  wire logic [gfa_pkg::WordW-1:0]  i_a,
    input  wire logic [gfa_pkg::WordW-1:0]  i_b,
    output gfa_pkg::t_sts                   o_sts,
    output logic [gfa_pkg::WordW-1:0]       o_result
);
    logic [gfa_pkg::WordW-1:0] r_a, r_b, r_braw, r_acc, r_base, r_e;
    logic [gfa_pkg::WordW-1:0] r_x, r_y;
    logic [2:0]                r_ph;
    logic                      r_busy;
    logic [gfa_pkg::WordW-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [gfa_pkg::WordW-1:0] r_lo, r_hi;
    logic [gfa_pkg::WordW-1:0] n_simple, n_fold;
    logic [gfa_pkg::WordW-1:0] s_mx, s_my, s_pp;
    logic [31:0]               s_xh, s_yh;
    logic [gfa_pkg::WordW:0]   s_sum;
    logic [gfa_pkg::WordW-1:0] s_mid, s_lo, s_hi;
    logic [gfa_pkg::WordW-1:0] f_hh, f_hl, f_t0, f_t1, f_t2;
    logic [gfa_pkg::WordW:0]   f_s;
    localparam logic [2:0] PhLast = 3'd5;

    // Simple operations.
    always_comb begin
        s_sum = {1'b0, r_a} + {1'b0, r_b};
        unique case (gfa_pkg::t_op'(i_op))
            gfa_pkg::OP_ADD: begin
                n_simple = s_sum[gfa_pkg::WordW] ?
                    gfa_pkg::canon(s_sum[gfa_pkg::WordW-1:0] + gfa_pkg::FoldEps) :
                    gfa_pkg::canon(s_sum[gfa_pkg::WordW-1:0]);
            end
            gfa_pkg::OP_SUB: begin
                n_simple = (r_a >= r_b) ? (r_a - r_b) : (gfa_pkg::FieldP - (r_b - r_a));
            end
            gfa_pkg::OP_NEG: begin
                n_simple = (r_a == '0) ? '0 : (gfa_pkg::FieldP - r_a);
            end
            gfa_pkg::OP_POW, gfa_pkg::OP_INV: begin
                n_simple = 64'd1;
            end
            default: begin
                n_simple = '0;
            end
        endcase
    end

    // Partial product select: phase 0..3 picks one 32x32 product.
    always_comb begin
        s_xh = r_ph[1] ? r_x[63:32] : r_x[31:0];
        s_yh = r_ph[0] ? r_y[63:32] : r_y[31:0];
        s_pp = {32'd0, s_xh} * {32'd0, s_yh};
        s_mid = {32'd0, r_p00[63:32]} + {32'd0, r_p01[31:0]} + {32'd0, r_p10[31:0]};
        s_lo = {s_mid[31:0], r_p00[31:0]};
        s_hi = r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]} + {32'd0, s_mid[63:32]};
    end

    always_comb begin
        f_hh = {32'd0, r_hi[63:32]};
        f_hl = {32'd0, r_hi[31:0]};
        f_t0 = r_lo - f_hh;
        if (r_lo < f_hh) begin
            f_t0 = f_t0 - gfa_pkg::FoldEps;
        end
        f_t1 = (f_hl << 32) - f_hl;
        f_s = {1'b0, f_t0} + {1'b0, f_t1};
        f_t2 = f_s[gfa_pkg::WordW-1:0];
        if (f_s[gfa_pkg::WordW]) begin
            f_t2 = f_t2 + gfa_pkg::FoldEps;
        end
        n_fold = gfa_pkg::canon(f_t2);
    end

    always_comb begin
        unique case (i_cmd.msel)
            gfa_pkg::MS_AB: begin s_mx = r_a;   s_my = r_b;    end
            gfa_pkg::MS_AP: begin s_mx = r_acc; s_my = r_base; end
            default:        begin s_mx = r_base; s_my = r_base; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= '0;
        end else if (i_cmd.mul_go) begin
            r_busy <= 1'b1;
            r_ph   <= '0;
        end else if (r_busy) begin
            r_ph   <= r_ph + 3'd1;
            if (r_ph == PhLast) begin
                r_busy <= 1'b0;
            end
        end
        if (i_cmd.mul_go) begin
            r_x <= s_mx;
            r_y <= s_my;
        end
        if (r_busy) begin
            unique case (r_ph)
                3'd0: r_p00 <= s_pp;
                3'd1: r_p01 <= s_pp;
                3'd2: r_p10 <= s_pp;
                3'd3: r_p11 <= s_pp;
                3'd4: begin r_lo <= s_lo; r_hi <= s_hi; end
                default: ;
            endcase
        end
        if (i_cmd.load) begin
            r_a    <= gfa_pkg::canon(i_a);
            r_b    <= gfa_pkg::canon(i_b);
            r_braw <= i_b;
        end
        if (i_cmd.simple) begin
            r_acc  <= n_simple;
            r_base <= r_a;
            r_e    <= (gfa_pkg::t_op'(i_op) == gfa_pkg::OP_INV) ? gfa_pkg::InvExp : r_braw;
        end
        if (i_cmd.wr_acc) begin
            r_acc <= n_fold;
        end
        if (i_cmd.wr_base) begin
            r_base <= n_fold;
        end
        if (i_cmd.shift_e) begin
            r_e <= r_e >> 1;
        end
    end

    assign o_sts.mul_done = r_busy && (r_ph == PhLast);
    assign o_sts.e_bit    = r_e[0];
    assign o_result       = r_acc;
endmodule
`default_nettype wire

[design/gfa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_ctrl: request sequencer for the Goldilocks field ALU
// Walks square-and-multiply over 64 exponent bits and handles the handshake.
// ----------------------------------------------------------------------------
module gfa_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [gfa_pkg::OpW-1:0] i_op,
    output logic [gfa_pkg::OpW-1:0]      o_op,
    output gfa_pkg::t_cmd                o_cmd,
    input  wire gfa_pkg::t_sts           i_sts,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready
);
    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MULAB, S_BIT, S_MULAP, S_SQ, S_OUT
    } t_state;

    t_state r_state;
    logic [gfa_pkg::OpW-1:0] r_op;
    logic [gfa_pkg::ExpCntW-1:0] r_cnt;
    logic r_out_valid, r_wait;

    assign o_op        = r_op;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = i_in_valid && o_in_ready;
        unique case (r_state)
            S_PREP: o_cmd.simple = 1'b1;
            S_MULAB: begin
                o_cmd.msel   = gfa_pkg::MS_AB;
                o_cmd.mul_go = !r_wait;
                o_cmd.wr_acc = i_sts.mul_done;
            end
            S_BIT: o_cmd.msel = gfa_pkg::MS_AB;
            S_MULAP: begin
                o_cmd.msel   = gfa_pkg::MS_AP;
                o_cmd.mul_go = !r_wait;
                o_cmd.wr_acc = i_sts.mul_done;
            end
            S_SQ: begin
                o_cmd.msel    = gfa_pkg::MS_SQ;
                o_cmd.mul_go  = !r_wait;
                o_cmd.wr_base = i_sts.mul_done;
                o_cmd.shift_e = i_sts.mul_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wait      <= 1'b0;
            r_cnt       <= '0;
            r_op        <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_op    <= i_op;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt <= '0;
                    priority if (gfa_pkg::t_op'(r_op) == gfa_pkg::OP_MUL) begin
                        r_state <= S_MULAB;
                    end else if (gfa_pkg::t_op'(r_op) == gfa_pkg::OP_POW ||
                                 gfa_pkg::t_op'(r_op) == gfa_pkg::OP_INV) begin
                        r_state <= S_BIT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MULAB: begin
                    r_wait <= !i_sts.mul_done;
                    if (i_sts.mul_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_BIT: begin
                    priority if (r_cnt[gfa_pkg::ExpCntW-1]) begin
                        r_state <= S_OUT;
                    end else if (i_sts.e_bit) begin
                        r_state <= S_MULAP;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_MULAP: begin
                    r_wait <= !i_sts.mul_done;
                    if (i_sts.mul_done) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_wait <= !i_sts.mul_done;
                    if (i_sts.mul_done) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_BIT;
                    end
                end
                default: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) (r_state != S_IDLE) |-> !o_in_ready;
    endproperty
    assert property (p_no_accept_busy) else $error("ready while busy");

    property p_one_write;
        @(posedge i_clk) disable iff (!i_rst_n) !(o_cmd.wr_acc && o_cmd.wr_base);
    endproperty
    assert property (p_one_write) else $error("acc and base written together");

    property p_done_in_mul;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_sts.mul_done |-> (r_state == S_MULAB || r_state == S_MULAP || r_state == S_SQ);
    endproperty
    assert property (p_done_in_mul) else $error("product finished outside a multiply step");
endmodule
`default_nettype wire
